// File: design/scp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scp_pkg
// Shared types and constants of the serial angle command parser.
// ----------------------------------------------------------------------------
package scp_pkg;

  localparam int unsigned LineMaxDef = 15;
  localparam int unsigned CountW     = 4;
  localparam int unsigned CharW      = 8;
  localparam int unsigned KindW      = 3;
  localparam int unsigned ValueW     = 17;
  localparam int unsigned LimitW     = 8;

  localparam logic [LimitW-1:0] LimitReset = LimitW'(10);
  localparam logic [ValueW-1:0] MagMax     = ValueW'(65535);

  localparam logic [CharW-1:0] ChCr    = 8'd13;
  localparam logic [CharW-1:0] ChLf    = 8'd10;
  localparam logic [CharW-1:0] ChLoR   = 8'h72;
  localparam logic [CharW-1:0] ChUpR   = 8'h52;
  localparam logic [CharW-1:0] ChLoC   = 8'h63;
  localparam logic [CharW-1:0] ChUpC   = 8'h43;
  localparam logic [CharW-1:0] ChMinus = 8'h2d;
  localparam logic [CharW-1:0] ChPlus  = 8'h2b;
  localparam logic [CharW-1:0] ChZero  = 8'h30;
  localparam logic [CharW-1:0] ChNine  = 8'h39;

  typedef enum logic [KindW-1:0] {
    KindReset    = 3'd0,
    KindCal      = 3'd1,
    KindTarget   = 3'd2,
    KindCalErr   = 3'd3,
    KindTargetErr = 3'd4
  } kind_e;

  typedef struct packed {
    logic                     fire;
    kind_e                    kind;
    logic signed [ValueW-1:0] value;
  } cmd_t;

endpackage

// File: design/serial_angle_command_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// serial_angle_command_parser
// Parses received text lines into reset, calibrate and target commands.
//
// Input channel rx_*: one received byte per word, valid/ready handshake.
// Output channel cmd_*: one command word (kind and signed value) for each
// non-empty line closed by CR or LF; other bytes give no word.
// cfg_we_i/cfg_wdata_i write the target clamp limit (reset value 10).
// The command is registered; it appears the cycle after its closing byte is taken.
// Throughput: one byte per cycle while rx_ready_o is high; the line state updates in the same cycle
// the byte is taken, and the command goes to a single output register.
// rx_ready_o stays high while the output register is empty or being taken;
// when the receiver stalls with a command pending, every byte is held off
// until the command is taken, whether or not it closes a line.
// Reset clears the line state and the output valid flag and sets the limit to 10.
// ----------------------------------------------------------------------------
module serial_angle_command_parser #(
  parameter int unsigned LINE_MAX = scp_pkg::LineMaxDef
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                rx_valid_i,
  output logic                                rx_ready_o,
  input  logic [scp_pkg::CharW-1:0]           rx_char_i,
  output logic                                cmd_valid_o,
  input  logic                                cmd_ready_i,
  output logic [scp_pkg::KindW-1:0]           command_kind_o,
  output logic signed [scp_pkg::ValueW-1:0]   command_value_o,
  input  logic                                cfg_we_i,
  input  logic [scp_pkg::LimitW-1:0]          cfg_wdata_i
);
  import scp_pkg::*;

  logic              take;
  logic [LimitW-1:0] limit_q;
  logic              valid_q;
  kind_e             kind_q;
  logic signed [ValueW-1:0] value_q;
  cmd_t              cmd;

  assign rx_ready_o = !valid_q || cmd_ready_i;
  assign take       = rx_valid_i && rx_ready_o;

  scp_line_parser #(
    .LINE_MAX (LINE_MAX)
  ) u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .take_i    (take),
    .rx_char_i (rx_char_i),
    .limit_i   (limit_q),
    .cmd_o     (cmd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LimitReset;
      valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
      if (cmd.fire) begin
        valid_q <= 1'b1;
      end else if (cmd_ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd.fire) begin
      kind_q  <= cmd.kind;
      value_q <= cmd.value;
    end
  end

  assign cmd_valid_o     = valid_q;
  assign command_kind_o  = kind_q;
  assign command_value_o = value_q;

endmodule

// File: design/scp_line_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scp_line_parser
// Per-line state and command decode; one byte per cycle while take_i is high.
// ----------------------------------------------------------------------------
module scp_line_parser #(
  parameter int unsigned LINE_MAX = scp_pkg::LineMaxDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         take_i,
  input  logic [scp_pkg::CharW-1:0]    rx_char_i,
  input  logic [scp_pkg::LimitW-1:0]   limit_i,
  output scp_pkg::cmd_t                cmd_o
);
  import scp_pkg::*;

  localparam logic [1:0] ModeNumber = 2'd0;
  localparam logic [1:0] ModeReset  = 2'd1;
  localparam logic [1:0] ModeCal    = 2'd2;
  localparam logic [CountW-1:0] CountMax = CountW'(LINE_MAX);

  logic [CountW-1:0] count_q, count_d;
  logic [1:0]        mode_q, mode_d;
  logic              neg_q, neg_d;
  logic              bad_q, bad_d;
  logic [ValueW-1:0] mag_q, mag_d;

  logic              is_eol, is_digit, take_digit;
  logic [ValueW+3:0] acc_sum;
  logic [ValueW-1:0] acc_sat;
  logic signed [ValueW-1:0] pos_mag, neg_mag, pos_lim, neg_lim, target_val;

  assign is_eol   = (rx_char_i == ChCr) || (rx_char_i == ChLf);
  assign is_digit = (rx_char_i >= ChZero) && (rx_char_i <= ChNine);
  assign acc_sum  = ({4'b0, mag_q} << 3) + ({4'b0, mag_q} << 1)
                  + {(ValueW+4-CharW)'(0), rx_char_i - ChZero};
  assign acc_sat  = (acc_sum > {4'b0, MagMax}) ? MagMax : acc_sum[ValueW-1:0];

  assign pos_mag = signed'(mag_q);
  assign neg_mag = -pos_mag;
  assign pos_lim = signed'({(ValueW-LimitW)'(0), limit_i});
  assign neg_lim = -pos_lim;

  always_comb begin
    if (neg_q) begin
      target_val = (pos_mag > pos_lim) ? neg_lim : neg_mag;
    end else begin
      target_val = (pos_mag > pos_lim) ? pos_lim : pos_mag;
    end
  end

  always_comb begin
    count_d    = count_q;
    mode_d     = mode_q;
    neg_d      = neg_q;
    bad_d      = bad_q;
    mag_d      = mag_q;
    take_digit = 1'b0;
    cmd_o      = '{fire: 1'b0, kind: KindReset, value: '0};
    if (take_i) begin
      if (is_eol) begin
        if (count_q != '0) begin
          cmd_o.fire = 1'b1;
          case (mode_q)
            ModeReset: begin
              cmd_o.kind = KindReset;
            end
            ModeCal: begin
              if (bad_q || (mag_q == '0)) begin
                cmd_o.kind = KindCalErr;
              end else begin
                cmd_o.kind  = KindCal;
                cmd_o.value = neg_q ? neg_mag : pos_mag;
              end
            end
            default: begin
              if (bad_q) begin
                cmd_o.kind = KindTargetErr;
              end else begin
                cmd_o.kind  = KindTarget;
                cmd_o.value = target_val;
              end
            end
          endcase
          count_d = '0;
          mode_d  = ModeNumber;
          neg_d   = 1'b0;
          bad_d   = 1'b0;
          mag_d   = '0;
        end
      end else if (count_q < CountMax) begin
        count_d = count_q + 1'b1;
        if (count_q == '0) begin
          if ((rx_char_i == ChLoR) || (rx_char_i == ChUpR)) begin
            mode_d = ModeReset;
          end else if ((rx_char_i == ChLoC) || (rx_char_i == ChUpC)) begin
            mode_d = ModeCal;
          end else if (rx_char_i == ChMinus) begin
            neg_d = 1'b1;
          end else if (rx_char_i != ChPlus) begin
            take_digit = 1'b1;
          end
        end else if (mode_q == ModeReset) begin
          take_digit = 1'b0;
        end else if ((mode_q == ModeCal) && (count_q == CountW'(1))) begin
          if (rx_char_i == ChMinus) begin
            neg_d = 1'b1;
          end else if (rx_char_i != ChPlus) begin
            take_digit = 1'b1;
          end
        end else begin
          take_digit = 1'b1;
        end
        if (take_digit && !bad_q) begin
          if (is_digit) begin
            mag_d = acc_sat;
          end else begin
            bad_d = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      mode_q  <= ModeNumber;
      neg_q   <= 1'b0;
      bad_q   <= 1'b0;
      mag_q   <= '0;
    end else begin
      count_q <= count_d;
      mode_q  <= mode_d;
      neg_q   <= neg_d;
      bad_q   <= bad_d;
      mag_q   <= mag_d;
    end
  end

endmodule

// File: tb/sv/serial_angle_command_parser_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// serial_angle_command_parser_test
// Self-checking bench for the serial angle command parser. Text lines are fed
// byte by byte through the rx handshake: a short directed set first, then
// random well-formed, broken and noise lines under several clamp limits.
// A parser model in the bench tracks the line state, predicts each command
// word and checks it against the cmd channel. Both channels idle at random outside the calm phase.
// ----------------------------------------------------------------------------
module serial_angle_command_parser_test;
  import scp_pkg::*;

  typedef enum logic [1:0] {
    LineNumber = 2'd0,
    LineReset  = 2'd1,
    LineCal    = 2'd2
  } line_mode_e;

  class parsed_commands;
    logic [LimitW-1:0] limit;
    logic [CountW-1:0] count;
    line_mode_e        mode;
    bit                neg;
    bit                bad;
    logic [ValueW-1:0] mag;
    kind_e             due_kind[$];
    logic [ValueW-1:0] due_value[$];
    int unsigned       mismatches;

    function new();
      limit      = LimitReset;
      mismatches = 0;
      clear_line();
    endfunction

    function void clear_line();
      count = '0;
      mode  = LineNumber;
      neg   = 1'b0;
      bad   = 1'b0;
      mag   = '0;
    endfunction

    function void queue_command(kind_e kind, int value);
      due_kind.push_back(kind);
      due_value.push_back(ValueW'(value));
    endfunction

    function void take_digit(logic [CharW-1:0] ch);
      int unsigned next;
      if (bad) return;
      if (ch >= ChZero && ch <= ChNine) begin
        next = 32'(mag) * 10 + 32'(ch) - 32'(ChZero);
        mag  = (next > 32'(MagMax)) ? MagMax : ValueW'(next);
      end else begin
        bad = 1'b1;
      end
    endfunction

    function void take_byte(logic [CharW-1:0] ch);
      int value;
      if (ch == ChCr || ch == ChLf) begin
        if (count == 0) return;
        value = neg ? -int'(mag) : int'(mag);
        case (mode)
          LineReset: begin
            queue_command(KindReset, 0);
          end
          LineCal: begin
            if (bad || mag == 0) queue_command(KindCalErr, 0);
            else queue_command(KindCal, value);
          end
          default: begin
            if (bad) begin
              queue_command(KindTargetErr, 0);
            end else begin
              if (value > int'(limit)) value = int'(limit);
              if (value < -int'(limit)) value = -int'(limit);
              queue_command(KindTarget, value);
            end
          end
        endcase
        clear_line();
        return;
      end
      if (count >= LineMaxDef) return;
      if (count == 0) begin
        if (ch == ChLoR || ch == ChUpR) mode = LineReset;
        else if (ch == ChLoC || ch == ChUpC) mode = LineCal;
        else if (ch == ChMinus) neg = 1'b1;
        else if (ch != ChPlus) take_digit(ch);
      end else if (mode != LineReset) begin
        if (mode == LineCal && count == 1) begin
          if (ch == ChMinus) neg = 1'b1;
          else if (ch != ChPlus) take_digit(ch);
        end else begin
          take_digit(ch);
        end
      end
      count = count + 1'b1;
    endfunction

    function void check_command(logic [KindW-1:0] kind, logic [ValueW-1:0] value);
      if (due_kind.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected command word: kind %0d value %0d", kind, $signed(value));
        return;
      end
      if (kind !== due_kind[0] || value !== due_value[0]) begin
        mismatches++;
        if (mismatches <= 10)
          $display("command mismatch: kind %0d value %0d, expected kind %0d value %0d",
                   kind, $signed(value), due_kind[0], $signed(due_value[0]));
      end
      void'(due_kind.pop_front());
      void'(due_value.pop_front());
    endfunction

    function int unsigned pending();
      return due_kind.size();
    endfunction
  endclass

  logic                     clk_i = 1'b0;
  logic                     rst_ni;
  logic                     rx_valid_i;
  logic                     rx_ready_o;
  logic [CharW-1:0]         rx_char_i;
  logic                     cmd_valid_o;
  logic                     cmd_ready_i;
  logic [KindW-1:0]         command_kind_o;
  logic signed [ValueW-1:0] command_value_o;
  logic                     cfg_we_i;
  logic [LimitW-1:0]        cfg_wdata_i;

  parsed_commands parsed = new();
  bit             calm = 1'b0;
  int unsigned    sent_count = 0;

  serial_angle_command_parser dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .rx_valid_i     (rx_valid_i),
    .rx_ready_o     (rx_ready_o),
    .rx_char_i      (rx_char_i),
    .cmd_valid_o    (cmd_valid_o),
    .cmd_ready_i    (cmd_ready_i),
    .command_kind_o (command_kind_o),
    .command_value_o(command_value_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i)
  );

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni && cmd_valid_o && cmd_ready_i)
      parsed.check_command(command_kind_o, command_value_o);
    cmd_ready_i <= calm || ($urandom_range(0, 99) >= 24);
  end

  task automatic send_byte(input logic [CharW-1:0] ch);
    int unsigned gap;
    gap = 0;
    while (!calm && $urandom_range(0, 99) < 24) gap++;
    if (gap != 0) begin
      rx_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    rx_valid_i <= 1'b1;
    rx_char_i  <= ch;
    do @(posedge clk_i); while (!rx_ready_o);
    parsed.take_byte(ch);
    sent_count++;
  endtask

  task automatic send_line(input string body, input bit use_cr);
    foreach (body[i]) send_byte(body[i]);
    send_byte(use_cr ? ChCr : ChLf);
  endtask

  task automatic send_random_line();
    logic [CharW-1:0] text[$];
    int unsigned      pick;
    int unsigned      len;
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      // empty line
    end else if (pick < 20) begin
      text.push_back($urandom_range(0, 1) ? ChLoR : ChUpR);
      repeat ($urandom_range(0, 4)) text.push_back(8'($urandom_range(32, 126)));
    end else if (pick < 88) begin
      if (pick < 45) text.push_back($urandom_range(0, 1) ? ChLoC : ChUpC);
      case ($urandom_range(0, 3))
        0: text.push_back(ChMinus);
        1: text.push_back(ChPlus);
        default: ;
      endcase
      if (pick >= 75) len = $urandom_range(12, 19);
      else if ($urandom_range(0, 9) == 0) len = $urandom_range(4, 6);
      else len = $urandom_range(0, 3);
      repeat (len) text.push_back(8'(ChZero + $urandom_range(0, 9)));
      if ($urandom_range(0, 9) == 0)
        text.insert($urandom_range(0, text.size()), 8'($urandom_range(0, 255)));
    end else begin
      repeat ($urandom_range(1, 18)) text.push_back(8'($urandom_range(0, 255)));
    end
    text.push_back($urandom_range(0, 1) ? ChCr : ChLf);
    foreach (text[i]) send_byte(text[i]);
  endtask

  task automatic set_limit(input logic [LimitW-1:0] value);
    rx_valid_i <= 1'b0;
    while (parsed.pending() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
    cfg_wdata_i <= value;
    cfg_we_i    <= 1'b1;
    @(posedge clk_i);
    cfg_we_i     <= 1'b0;
    parsed.limit = value;
  endtask

  initial begin
    int unsigned phase_end;
    rst_ni      <= 1'b0;
    rx_valid_i  <= 1'b0;
    rx_char_i   <= '0;
    cmd_ready_i <= 1'b0;
    cfg_we_i    <= 1'b0;
    cfg_wdata_i <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    send_line("", 1'b0);
    send_line("r", 1'b1);
    send_line("C-9", 1'b0);
    send_line("c+0", 1'b1);
    send_line("-", 1'b0);
    send_line("+7x", 1'b1);
    send_line("c5-", 1'b0);
    send_line("-1234567890123456", 1'b1);

    for (int p = 0; p < 5; p++) begin
      case (p)
        1: set_limit(8'd0);
        2: set_limit(8'd255);
        3: set_limit(8'($urandom_range(1, 254)));
        4: set_limit(8'd1);
        default: ;
      endcase
      calm      = (p == 2);
      phase_end = sent_count + 320;
      while (sent_count < phase_end) send_random_line();
    end
    calm = 1'b0;

    rx_valid_i <= 1'b0;
    while (parsed.pending() != 0) @(posedge clk_i);
    repeat (5) @(posedge clk_i);
    if (parsed.mismatches == 0 && parsed.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #4ms;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
